/* hdl/twcs_pkg.sv */
// Shared constants, types and register codes of the textured wall column sampler.
package twcs_pkg;

  localparam int TEX_WIDTH   = 64;
  localparam int TEX_HEIGHT  = 64;
  localparam int MAX_ROWS    = 64;
  localparam int TW_BITS     = $clog2(TEX_WIDTH);
  localparam int TH_BITS     = $clog2(TEX_HEIGHT);
  localparam int ADDR_W      = 2 + TW_BITS + TH_BITS;
  localparam int STORE_DEPTH = 4 * TEX_WIDTH * TEX_HEIGHT;
  localparam int FRAC_BITS   = 22;
  localparam int CAM_FRAC_W  = FRAC_BITS - 14;
  localparam int DEN_W       = 16;
  localparam int NUM_W       = TH_BITS + 17;
  localparam int CNT_W       = $clog2(NUM_W + 1);
  localparam int ROW_W       = 6;
  localparam int COL_W       = 10;

  localparam logic [NUM_W-1:0] STEP_NUMERATOR = NUM_W'(TEX_HEIGHT) << 16;

  localparam logic [1:0] CFG_CAMERA_X    = 2'd0;
  localparam logic [1:0] CFG_CAMERA_Y    = 2'd1;
  localparam logic [1:0] CFG_SCREEN_ROWS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_DIV,
    ST_SCALE,
    ST_DRAW
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic              last;
  } read_req_t;

endpackage

/* hdl/twcs_ram.sv */
// Generic simple dual port RAM with registered read and read enable.
module twcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/twcs_divider.sv */
// Restoring divider, one quotient bit per cycle: texture height (Q16.16) over line height.
module twcs_divider import twcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  logic             running;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic [DEN_W-1:0] rem_next;
  logic             qbit;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = DEN_W'(trial - {1'b0, divisor});
      qbit     = 1'b1;
    end else begin
      rem_next = DEN_W'(trial);
      qbit     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(NUM_W);
        rem     <= '0;
        quo     <= STEP_NUMERATOR;
      end else if (running) begin
        rem   <= rem_next;
        quo   <= {quo[NUM_W-2:0], qbit};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* hdl/twcs_sequencer.sv */
// Column setup and row sequencer: texel writes, hit fraction, texture pick, step, start position, texel reads.
module twcs_sequencer import twcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [13:0]       texel_address,
  input  logic [31:0]       texel_value,
  input  logic [9:0]        screen_column,
  input  logic              hit_side,
  input  logic signed [15:0] ray_dir_x,
  input  logic signed [15:0] ray_dir_y,
  input  logic [15:0]       wall_distance,
  input  logic [15:0]       line_height,
  input  logic [6:0]        draw_first,
  input  logic [6:0]        draw_stop,
  input  logic [15:0]       camera_x,
  input  logic [15:0]       camera_y,
  input  logic [6:0]        screen_rows,
  input  logic              adv,
  output read_req_t         req,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [31:0]       wr_data
);

  state_t state, state_next;

  logic [COL_W-1:0]      column_r;
  logic [CAM_FRAC_W-1:0] cam_low;
  logic [15:0]           dist_r;
  logic signed [15:0]    dir_r;
  logic                  mirror_r;
  logic [1:0]            active_texture;
  logic [DEN_W-1:0]      lh_eff;
  logic signed [16:0]    start_term;
  logic [6:0]            row_counter;
  logic [6:0]            stop_r;
  logic signed [32:0]    prod;
  logic [31:0]           tex_step;
  logic [31:0]           tex_position;
  logic [TW_BITS-1:0]    tex_column;

  logic                  accept_draw;
  logic                  x_pos, y_pos;
  logic [FRAC_BITS-1:0]  frac;
  logic [TW_BITS-1:0]    texx;
  logic signed [48:0]    scaled;
  logic                  div_start, div_done;
  logic [NUM_W-1:0]      quotient;
  logic                  issue;

  twcs_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (lh_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_stall    = (state != ST_IDLE);
  assign accept_draw = (state == ST_IDLE) && in_valid && mode;
  assign x_pos       = !ray_dir_x[15] && (ray_dir_x != 16'sd0);
  assign y_pos       = !ray_dir_y[15] && (ray_dir_y != 16'sd0);

  assign wr_en   = (state == ST_IDLE) && in_valid && !mode
                   && (32'(texel_address) < 32'(STORE_DEPTH));
  assign wr_addr = ADDR_W'(texel_address);
  assign wr_data = texel_value;

  // fraction of the hit point: low bits of camera<<14 plus distance * direction
  assign frac   = {cam_low, 14'b0} + prod[FRAC_BITS-1:0];
  assign texx   = frac[FRAC_BITS-1 -: TW_BITS];
  assign scaled = start_term * $signed({1'b0, tex_step});

  assign div_start = (state == ST_MULT);

  always_comb begin
    req.valid  = (state == ST_DRAW) && (row_counter < stop_r);
    req.addr   = {active_texture, tex_position[16 +: TH_BITS], tex_column};
    req.column = column_r;
    req.row    = row_counter[ROW_W-1:0];
    req.last   = ((row_counter + 7'd1) == stop_r);
  end
  assign issue = req.valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_draw) state_next = ST_MULT;
      end
      ST_MULT: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        state_next = ST_DRAW;
      end
      ST_DRAW: begin
        if (!req.valid || (issue && req.last)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      tex_position   <= '0;
      tex_step       <= '0;
      tex_column     <= '0;
      active_texture <= '0;
    end else begin
      if (accept_draw) begin
        column_r       <= screen_column;
        cam_low        <= hit_side ? camera_x[CAM_FRAC_W-1:0] : camera_y[CAM_FRAC_W-1:0];
        dist_r         <= wall_distance;
        dir_r          <= hit_side ? ray_dir_x : ray_dir_y;
        mirror_r       <= hit_side ? ray_dir_y[15] : x_pos;
        active_texture <= {hit_side, hit_side ? y_pos : x_pos};
        lh_eff         <= (line_height == 16'd0) ? DEN_W'(1) : line_height;
        start_term     <= 17'(draw_first)
                          + 17'((line_height == 16'd0) ? 16'd0 : {1'b0, line_height[15:1]})
                          - 17'(screen_rows[6:1]);
        row_counter    <= draw_first;
        stop_r         <= (draw_stop > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : draw_stop;
      end
      if (state == ST_MULT) begin
        prod <= $signed({1'b0, dist_r}) * dir_r;
      end
      if ((state == ST_DIV) && div_done) begin
        tex_step   <= 32'(quotient);
        tex_column <= mirror_r ? ~texx : texx;
      end
      if (state == ST_SCALE) begin
        tex_position <= scaled[31:0];
      end
      if (issue) begin
        row_counter  <= row_counter + 7'd1;
        tex_position <= tex_position + tex_step;
      end
    end
  end

endmodule

/* hdl/textured_wall_column_sampler_unit.sv */
// Top level of the textured wall column sampler: config registers, texel store, output stage.
//
// Input channel (in_valid / in_stall): an item is taken when in_valid is high and in_stall
// low. A mode 0 item writes one texel into the store. A mode 1 item draws one
// wall column: in_stall stays high while the column is set up and its rows are issued.
// Column setup: operand multiply, then the step divider (23 quotient bits, one per cycle,
// then done), then the start position; then one texel read per row through the single
// read port of the store. A column of n rows (n up to 64) keeps in_stall high until its
// last row is issued; an empty column returns to idle after setup.
// Output channel (out_valid / out_stall): one item per drawn row, last_pixel marks the
// final row. The texel read data register is the output register; while out_stall is high
// the item holds and row issue pauses. An empty column produces no item.
// Config port (cfg_valid / cfg_ready, always ready): index 0 camera_x, 1 camera_y,
// 2 screen_rows; write only while idle.
// Reset (rst, synchronous): clears control state and config to camera 0,0 and 64 rows.
// The texel store is not cleared; texels must be loaded before they are drawn.
module textured_wall_column_sampler_unit import twcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [13:0]       texel_address,
  input  logic [31:0]       texel_value,
  input  logic [9:0]        screen_column,
  input  logic              hit_side,
  input  logic signed [15:0] ray_dir_x,
  input  logic signed [15:0] ray_dir_y,
  input  logic [15:0]       wall_distance,
  input  logic [15:0]       line_height,
  input  logic [6:0]        draw_first,
  input  logic [6:0]        draw_stop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [9:0]        out_column,
  output logic [5:0]        out_row,
  output logic [31:0]       pixel_color,
  output logic              last_pixel,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  logic [15:0]       camera_x;
  logic [15:0]       camera_y;
  logic [6:0]        screen_rows;
  read_req_t         req;
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x    <= '0;
      camera_y    <= '0;
      screen_rows <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAMERA_X:    camera_x    <= cfg_data;
        CFG_CAMERA_Y:    camera_y    <= cfg_data;
        CFG_SCREEN_ROWS: screen_rows <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  twcs_sequencer u_sequencer (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .texel_address (texel_address),
    .texel_value   (texel_value),
    .screen_column (screen_column),
    .hit_side      (hit_side),
    .ray_dir_x     (ray_dir_x),
    .ray_dir_y     (ray_dir_y),
    .wall_distance (wall_distance),
    .line_height   (line_height),
    .draw_first    (draw_first),
    .draw_stop     (draw_stop),
    .camera_x      (camera_x),
    .camera_y      (camera_y),
    .screen_rows   (screen_rows),
    .adv           (rd_en),
    .req           (req),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  // output stage moves whenever it is empty or being taken
  assign rd_en = !out_valid || !out_stall;

  twcs_ram #(
    .WIDTH (32),
    .DEPTH (STORE_DEPTH)
  ) u_texel_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (req.addr),
    .rd_data (pixel_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_en) begin
      out_valid  <= req.valid;
      out_column <= req.column;
      out_row    <= req.row;
      last_pixel <= req.last;
    end
  end

  a_draw_holds_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode) |=> in_stall)
    else $error("column item accepted but input not stalled");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && req.valid))
    else $error("texel write overlaps a column read");

  a_last_ends_column: assert property (@(posedge clk) disable iff (rst)
    (req.valid && rd_en && req.last) |=> !req.valid)
    else $error("row issued after the last pixel of a column");

endmodule
